>>> rtl/core/avs_pkg.sv
// ----------------------------------------------------------------------------
// avs_pkg
// Shared types and constants for the ascending value sorter: the value
// width and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package avs_pkg;

    // width of one value
    localparam int VALUE_W = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic insert;   // take s_value into the sorted cell chain
        logic shift;    // move the chain one place towards the head
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic last_one; // exactly one value still held
    } sts_t;

endpackage

>>> rtl/core/avs_ctrl.sv
// ----------------------------------------------------------------------------
// avs_ctrl
// Controller for the ascending value sorter: collects beats up to the last,
// then streams the sorted set out one beat per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module avs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_last,
    output logic           m_valid,
    input  logic           m_ready,
    output avs_pkg::cmd_t  cmd,
    input  avs_pkg::sts_t  sts
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    logic state_reg;
    logic state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_COLLECT: begin
                s_ready    = 1'b1;
                cmd.insert = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_valid   = 1'b1;
                cmd.shift = m_ready;
                if (m_ready && sts.last_one) begin
                    state_next = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

endmodule

>>> rtl/core/avs_dpath.sv
// ----------------------------------------------------------------------------
// avs_dpath
// Datapath for the ascending value sorter: a chain of compare-and-insert
// cells kept in ascending order, a fill count and a dropped-value flag.
// ----------------------------------------------------------------------------
module avs_dpath #(
    parameter int MAX_COUNT = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  avs_pkg::cmd_t                      cmd,
    output avs_pkg::sts_t                      sts,
    input  logic signed [avs_pkg::VALUE_W-1:0] s_value,
    output logic signed [avs_pkg::VALUE_W-1:0] m_sorted_value,
    output logic                               m_final_res,
    output logic                               m_overflow
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    logic signed [avs_pkg::VALUE_W-1:0] cell_reg [MAX_COUNT];
    logic [CNT_W-1:0]                   fill_reg;
    logic [CNT_W-1:0]                   fill_next;
    logic                               dropped_reg;
    logic                               dropped_next;
    logic                               full;
    logic [MAX_COUNT-1:0]               ins;

    assign full = (fill_reg == CNT_W'(MAX_COUNT));

    // insert position: first cell that is empty or holds a greater value
    for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
        assign ins[i] = !full &&
                        ((fill_reg <= CNT_W'(i)) || (s_value < cell_reg[i]));

        // each cell keeps, takes the new value, or takes its neighbour
        always_ff @(posedge aclk) begin
            if (cmd.insert) begin
                if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
                    cell_reg[i] <= cell_reg[(i > 0) ? i - 1 : 0];
                end else if (ins[i]) begin
                    cell_reg[i] <= s_value;
                end
            end else if (cmd.shift) begin
                if (i < MAX_COUNT - 1) begin
                    cell_reg[i] <= cell_reg[(i < MAX_COUNT - 1) ? i + 1 : i];
                end
            end
        end
    end

    // fill count and dropped flag
    always_comb begin
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        if (cmd.insert) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end else if (cmd.shift) begin
            fill_next = fill_reg - CNT_W'(1);
            if (fill_reg == CNT_W'(1)) begin
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
        end
    end

    // head of the chain is the next result beat
    assign sts.last_one    = (fill_reg == CNT_W'(1));
    assign m_sorted_value  = cell_reg[0];
    assign m_final_res     = sts.last_one;
    assign m_overflow      = dropped_reg;

endmodule

>>> rtl/core/ascending_value_sorter_top.sv
// ----------------------------------------------------------------------------
// ascending_value_sorter_top
// Sorts a set of signed values into ascending order as they arrive and
// streams the set out when the beat flagged last has been taken.
//
//   channel   direction  payload                                 handshake
//   s_        in         s_value[31:0] signed, s_last            s_valid/s_ready
//   m_        out        m_sorted_value[31:0] signed,            m_valid/m_ready
//                        m_final_res, m_overflow
//
// Collecting takes one input beat per cycle: each value drops into its place
// in the compare-and-insert cell chain in the cycle it is accepted.
// The held values are then emitted from the head of the chain at one result
// beat per cycle while m_ready is high; no input is taken until the final beat has gone.
// Beats past MAX_COUNT are dropped and the set's results carry m_overflow.
// Reset clears the fill count, the overflow flag and the controller state.
// m_ready low simply holds the current result beat.
// ----------------------------------------------------------------------------
module ascending_value_sorter_top #(
    parameter int MAX_COUNT = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [avs_pkg::VALUE_W-1:0] s_value,
    input  logic                               s_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [avs_pkg::VALUE_W-1:0] m_sorted_value,
    output logic                               m_final_res,
    output logic                               m_overflow
);

    avs_pkg::cmd_t cmd;
    avs_pkg::sts_t sts;

    // controller
    avs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath
    avs_dpath #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_value        (s_value),
        .m_sorted_value (m_sorted_value),
        .m_final_res    (m_final_res),
        .m_overflow     (m_overflow)
    );

endmodule
